// ===== hdl/tts_pkg.sv =====
package tts_pkg;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_DELETE   = 2'd2;
    localparam logic [1:0] OP_DISPATCH = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_NONE  = 3'd4;

    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    localparam logic [7:0] PENDING_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] task_tag;
        logic [31:0] start_delay;
        logic [31:0] repeat_period;
        logic [7:0]  slot_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  result_slot;
        logic [15:0] result_tag;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] delay;
        logic [31:0] period;
        logic [7:0]  pending;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DEL,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic accept;
        logic add_step;
        logic del;
        logic scan;
        logic resp;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_tick;
        logic add_done;
        logic scan_done;
        logic out_free;
    } t_ctl_stat;

endpackage

// ===== hdl/tts_ram.sv =====
module tts_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/tts_ctrl.sv =====
module tts_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [1:0]            i_operation,
    input  tts_pkg::t_ctl_stat    i_stat,
    output logic                  o_in_ready,
    output tts_pkg::t_ctl_cmd     o_cmd
);

    tts_pkg::t_state r_state;
    tts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            tts_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_operation)
                        tts_pkg::OP_ADD:    n_state = tts_pkg::S_ADD;
                        tts_pkg::OP_DELETE: n_state = tts_pkg::S_DEL;
                        default:            n_state = tts_pkg::S_SCAN;
                    endcase
                end
            end
            tts_pkg::S_ADD: begin
                o_cmd.add_step = 1'b1;
                if (i_stat.add_done) begin
                    n_state = tts_pkg::S_RESP;
                end
            end
            tts_pkg::S_DEL: begin
                o_cmd.del = 1'b1;
                n_state   = tts_pkg::S_RESP;
            end
            tts_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = i_stat.is_tick ? tts_pkg::S_IDLE : tts_pkg::S_RESP;
                end
            end
            tts_pkg::S_RESP: begin
                o_cmd.resp = 1'b1;
                if (i_stat.out_free) begin
                    n_state = tts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/tts_datapath.sv =====
module tts_datapath #(
    parameter int MAX_TASKS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tts_pkg::t_in_item    i_in_item,
    input  tts_pkg::t_ctl_cmd    i_cmd,
    output tts_pkg::t_ctl_stat   o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output tts_pkg::t_out_item   o_out_item
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
    localparam int REC_W = $bits(tts_pkg::t_rec);

    tts_pkg::t_in_item           r_item;
    logic [IDX_W-1:0]            r_idx;
    logic [MAX_TASKS-1:0]        r_valid;
    logic [tts_pkg::CNT_W-1:0]   r_count;
    logic                        r_hold_valid;
    logic [IDX_W-1:0]            r_hold_slot;
    logic [15:0]                 r_hold_tag;
    tts_pkg::t_out_item          r_resp;
    logic                        r_out_valid;
    tts_pkg::t_out_item          r_out;

    logic [REC_W-1:0]            rd_data;
    tts_pkg::t_rec               rd_rec;
    tts_pkg::t_rec               nx_rec;
    tts_pkg::t_rec               wr_rec;
    logic                        wr_en;
    logic [IDX_W-1:0]            rd_addr;
    logic                        is_dispatch;
    logic                        at_last;
    logic                        slot_ok;
    logic                        out_free;
    logic                        hit;
    logic                        need_push;
    logic                        advance;
    logic                        limit_hit;
    logic                        add_free;
    logic                        del_in_range;
    logic [IDX_W-1:0]            del_idx;

    tts_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_TASKS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_idx),
        .i_wdata (wr_rec),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        rd_rec       = rd_data;
        is_dispatch  = (r_item.operation == tts_pkg::OP_DISPATCH);
        at_last      = (r_idx == LAST_IDX);
        slot_ok      = r_valid[r_idx];
        out_free     = !r_out_valid || i_out_ready;
        hit          = i_cmd.scan && is_dispatch && slot_ok && (rd_rec.pending != 8'd0);
        need_push    = hit && r_hold_valid;
        advance      = !(need_push && !out_free);
        limit_hit    = hit && ((r_count + tts_pkg::CNT_W'(1))
                              == tts_pkg::CNT_W'(tts_pkg::RESULT_LIMIT));
        add_free     = !slot_ok;
        del_in_range = (r_item.slot_index < 8'(MAX_TASKS));
        del_idx      = r_item.slot_index[IDX_W-1:0];

        nx_rec = rd_rec;
        if (is_dispatch) begin
            nx_rec.pending = rd_rec.pending - 8'd1;
        end else if (rd_rec.delay == 32'd0) begin
            if (rd_rec.pending != tts_pkg::PENDING_MAX) begin
                nx_rec.pending = rd_rec.pending + 8'd1;
            end
            nx_rec.delay = rd_rec.period;
        end else begin
            nx_rec.delay = rd_rec.delay - 32'd1;
        end

        wr_en  = 1'b0;
        wr_rec = nx_rec;
        if (i_cmd.scan && advance && slot_ok && (!is_dispatch || hit)) begin
            wr_en = 1'b1;
        end
        if (i_cmd.add_step && add_free) begin
            wr_en          = 1'b1;
            wr_rec.tag     = r_item.task_tag;
            wr_rec.delay   = r_item.start_delay;
            wr_rec.period  = r_item.repeat_period;
            wr_rec.pending = 8'd0;
        end

        rd_addr = '0;
        if (i_cmd.scan) begin
            rd_addr = (advance && !at_last) ? r_idx + IDX_W'(1) : r_idx;
        end

        o_stat.is_tick   = (r_item.operation == tts_pkg::OP_TICK);
        o_stat.add_done  = i_cmd.add_step && (add_free || at_last);
        o_stat.scan_done = i_cmd.scan && advance && (at_last || limit_hit);
        o_stat.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item  <= i_in_item;
            r_idx   <= '0;
            r_count <= '0;
        end else if (i_cmd.add_step && !o_stat.add_done) begin
            r_idx <= r_idx + IDX_W'(1);
        end else if (i_cmd.scan && advance && !at_last) begin
            r_idx <= r_idx + IDX_W'(1);
        end

        if (hit && advance) begin
            r_hold_slot <= r_idx;
            r_hold_tag  <= rd_rec.tag;
            r_count     <= r_count + tts_pkg::CNT_W'(1);
        end

        if (i_cmd.add_step) begin
            r_resp.result_tag <= 16'd0;
            r_resp.last       <= 1'b1;
            if (add_free) begin
                r_resp.status      <= tts_pkg::ST_OK;
                r_resp.result_slot <= 8'(r_idx);
            end else begin
                r_resp.status      <= tts_pkg::ST_FULL;
                r_resp.result_slot <= 8'(MAX_TASKS);
            end
        end else if (i_cmd.del) begin
            r_resp.result_slot <= 8'd0;
            r_resp.result_tag  <= 16'd0;
            r_resp.last        <= 1'b1;
            if (!del_in_range) begin
                r_resp.status <= tts_pkg::ST_RANGE;
            end else if (!r_valid[del_idx]) begin
                r_resp.status <= tts_pkg::ST_EMPTY;
            end else begin
                r_resp.status <= tts_pkg::ST_OK;
            end
        end else if (o_stat.scan_done) begin
            r_resp.last <= 1'b1;
            if (hit) begin
                r_resp.status      <= tts_pkg::ST_OK;
                r_resp.result_slot <= 8'(r_idx);
                r_resp.result_tag  <= rd_rec.tag;
            end else if (r_hold_valid) begin
                r_resp.status      <= tts_pkg::ST_OK;
                r_resp.result_slot <= 8'(r_hold_slot);
                r_resp.result_tag  <= r_hold_tag;
            end else begin
                r_resp.status      <= tts_pkg::ST_NONE;
                r_resp.result_slot <= 8'd0;
                r_resp.result_tag  <= 16'd0;
            end
        end

        if (need_push && advance) begin
            r_out.status      <= tts_pkg::ST_OK;
            r_out.result_slot <= 8'(r_hold_slot);
            r_out.result_tag  <= r_hold_tag;
            r_out.last        <= 1'b0;
        end else if (i_cmd.resp && out_free) begin
            r_out <= r_resp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.add_step && add_free) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (hit && advance && (rd_rec.period == 32'd0)) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (i_cmd.del && del_in_range) begin
                r_valid[del_idx] <= 1'b0;
            end

            if (i_cmd.accept) begin
                r_hold_valid <= 1'b0;
            end else if (hit && advance) begin
                r_hold_valid <= 1'b1;
            end

            if ((need_push && advance) || (i_cmd.resp && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== hdl/time_triggered_task_scheduler.sv =====
// Dispatch scans the slot table one slot per cycle, stalling on a hit while an earlier result
// cannot yet be passed to the output; tick scans the same way and never stalls.
// Add scans the valid bits one slot per cycle until the first free slot, or up to the last
// slot when the table is full; delete checks its slot directly without a scan.
// The slot memory and its registered read set the one-slot-per-cycle pace.
// Synchronous active-low reset clears all valid bits at once; the table is usable right after.
module time_triggered_task_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tts_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tts_pkg::t_out_item  o_out_item
);

    tts_pkg::t_ctl_cmd  cmd;
    tts_pkg::t_ctl_stat stat;

    tts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_item.operation),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    tts_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== sim/time_triggered_task_scheduler_tb.sv =====
`timescale 1ns / 1ps

module time_triggered_task_scheduler_tb;

    localparam int TASKS          = 16;
    localparam int CLK_NS         = 8;
    localparam int RANDOM_ITEMS   = 410;
    localparam int SATURATE_TICKS = 270;
    localparam int DRAIN_CYCLES   = 60;
    localparam longint TIMEOUT_CYCLES = 2_000_000;
    localparam int HOLD_FROM      = 2000;
    localparam int HOLD_TO        = 2600;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    tts_pkg::t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    tts_pkg::t_out_item out_item;

    tts_pkg::t_in_item  ops_to_send [$];
    tts_pkg::t_out_item reports_due [$];

    logic        tbl_used   [TASKS];
    logic [15:0] tbl_tag    [TASKS];
    logic [31:0] tbl_delay  [TASKS];
    logic [31:0] tbl_period [TASKS];
    logic [7:0]  tbl_runs   [TASKS];

    int        fails = 0;
    int        tx_gap = 0;
    int        rx_gap = 0;
    int        rx_draw;
    int        cycle_no = 0;
    logic      rx_hold;
    logic      calm;
    tts_pkg::t_out_item want;

    time_triggered_task_scheduler #(
        .MAX_TASKS(TASKS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    initial begin
        forever #(CLK_NS / 2) clk = ~clk;
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_NS);
        $display("time_triggered_task_scheduler_tb NOT OK");
        $finish;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            cycle_no <= 0;
        end else begin
            cycle_no <= cycle_no + 1;
        end
    end

    assign rx_hold = (cycle_no >= HOLD_FROM) && (cycle_no < HOLD_TO);
    assign calm    = (cycle_no[10:9] == 2'b11);

    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic drop_slot(int i);
        tbl_used[i]   = 1'b0;
        tbl_tag[i]    = '0;
        tbl_delay[i]  = '0;
        tbl_period[i] = '0;
        tbl_runs[i]   = '0;
    endtask

    task automatic scheduler_apply(tts_pkg::t_in_item it);
        tts_pkg::t_out_item rep;
        tts_pkg::t_out_item batch [tts_pkg::RESULT_LIMIT];
        int        n;
        int        free_at;
        n       = 0;
        free_at = TASKS;
        rep     = '0;
        rep.last = 1'b1;
        case (it.operation)
            tts_pkg::OP_TICK: begin
                for (int i = 0; i < TASKS; i++) begin
                    if (tbl_used[i]) begin
                        if (tbl_delay[i] == 0) begin
                            if (tbl_runs[i] != tts_pkg::PENDING_MAX) begin
                                tbl_runs[i] = tbl_runs[i] + 8'd1;
                            end
                            if (tbl_period[i] != 0) tbl_delay[i] = tbl_period[i];
                        end else begin
                            tbl_delay[i] = tbl_delay[i] - 32'd1;
                        end
                    end
                end
            end
            tts_pkg::OP_ADD: begin
                for (int i = 0; i < TASKS; i++) begin
                    if (!tbl_used[i]) begin
                        free_at = i;
                        break;
                    end
                end
                if (free_at == TASKS) begin
                    rep.status      = tts_pkg::ST_FULL;
                    rep.result_slot = 8'(TASKS);
                end else begin
                    tbl_used[free_at]   = 1'b1;
                    tbl_tag[free_at]    = it.task_tag;
                    tbl_delay[free_at]  = it.start_delay;
                    tbl_period[free_at] = it.repeat_period;
                    tbl_runs[free_at]   = '0;
                    rep.status          = tts_pkg::ST_OK;
                    rep.result_slot     = 8'(free_at);
                end
                reports_due.push_back(rep);
            end
            tts_pkg::OP_DELETE: begin
                if (it.slot_index >= TASKS) begin
                    rep.status = tts_pkg::ST_RANGE;
                end else begin
                    rep.status = tbl_used[it.slot_index] ? tts_pkg::ST_OK : tts_pkg::ST_EMPTY;
                    drop_slot(it.slot_index);
                end
                reports_due.push_back(rep);
            end
            tts_pkg::OP_DISPATCH: begin
                for (int i = 0; i < TASKS && n < tts_pkg::RESULT_LIMIT; i++) begin
                    if (tbl_runs[i] != 0) begin
                        batch[n].status      = tts_pkg::ST_OK;
                        batch[n].result_slot = 8'(i);
                        batch[n].result_tag  = tbl_tag[i];
                        batch[n].last        = 1'b0;
                        n++;
                        tbl_runs[i] = tbl_runs[i] - 8'd1;
                        if (tbl_period[i] == 0) drop_slot(i);
                    end
                end
                if (n == 0) begin
                    rep.status = tts_pkg::ST_NONE;
                    reports_due.push_back(rep);
                end else begin
                    for (int k = 0; k < n; k++) begin
                        rep      = batch[k];
                        rep.last = (k == n - 1);
                        reports_due.push_back(rep);
                    end
                end
            end
        endcase
    endtask

    task automatic push_op(logic [1:0] op, logic [15:0] tag, logic [31:0] dly,
                           logic [31:0] per, logic [7:0] idx);
        tts_pkg::t_in_item it;
        it.operation     = op;
        it.task_tag      = tag;
        it.start_delay   = dly;
        it.repeat_period = per;
        it.slot_index    = idx;
        ops_to_send.push_back(it);
    endtask

    task automatic push_random(logic [1:0] op);
        tts_pkg::t_in_item it;
        it.operation     = op;
        it.task_tag      = 16'($urandom());
        it.start_delay   = $urandom();
        it.repeat_period = $urandom();
        it.slot_index    = 8'($urandom());
        if (op == tts_pkg::OP_ADD) begin
            if ($urandom_range(0, 9) != 0) it.start_delay = $urandom_range(0, 4);
            if ($urandom_range(0, 9) != 0) it.repeat_period = $urandom_range(0, 3);
        end
        if (op == tts_pkg::OP_DELETE && $urandom_range(0, 3) != 0) begin
            it.slot_index = 8'($urandom_range(0, TASKS - 1));
        end
        ops_to_send.push_back(it);
    endtask

    task automatic check_field(string what, int expected_val, int actual_val);
        if (expected_val != actual_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, expected_val, actual_val);
            fails++;
        end
    endtask

    initial begin
        for (int i = 0; i < TASKS; i++) drop_slot(i);
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (in_valid && in_ready) scheduler_apply(in_item);
            if (!in_valid || in_ready) begin
                if (tx_gap != 0) begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end else if (ops_to_send.size() != 0) begin
                    in_item  <= ops_to_send.pop_front();
                    in_valid <= 1'b1;
                    tx_gap   <= idle_len();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_gap    <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (reports_due.size() == 0) begin
                    $display("%0t: unexpected item, expected none, %s%0d slot=%0d tag=%0d last=%0d",
                             $time, "actual status=", out_item.status,
                             out_item.result_slot, out_item.result_tag, out_item.last);
                    fails++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("status", want.status, out_item.status);
                    check_field("result_slot", want.result_slot, out_item.result_slot);
                    check_field("result_tag", want.result_tag, out_item.result_tag);
                    check_field("last", want.last, out_item.last);
                end
            end
            if (rx_hold) begin
                out_ready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap    <= rx_gap - 1;
                out_ready <= 1'b0;
            end else if (out_valid && out_ready) begin
                rx_draw   = idle_len();
                out_ready <= (rx_draw == 0);
                rx_gap    <= (rx_draw == 0) ? 0 : rx_draw - 1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int  made;
        int  long_at;
        int  r;
        int  n;
        bit  long_done;
        made      = 0;
        long_done = 1'b0;
        long_at   = $urandom_range(100, 300);

        push_op(tts_pkg::OP_DISPATCH, 16'h0000, 32'h0, 32'h0, 8'h00);
        push_op(tts_pkg::OP_TICK,     16'h0000, 32'h0, 32'h0, 8'h00);
        push_op(tts_pkg::OP_DELETE,   16'h0000, 32'h0, 32'h0, 8'hFF);
        push_op(tts_pkg::OP_DELETE,   16'h0000, 32'h0, 32'h0, 8'(TASKS));
        push_op(tts_pkg::OP_DELETE,   16'h0000, 32'h0, 32'h0, 8'(TASKS - 1));
        push_op(tts_pkg::OP_ADD,      16'hFFFF, 32'h0, 32'h0, 8'h00);
        push_op(tts_pkg::OP_ADD,      16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
        push_op(tts_pkg::OP_ADD,      16'h1234, 32'h1, 32'h1, 8'h00);
        repeat (3) push_op(tts_pkg::OP_TICK, 16'h0000, 32'h0, 32'h0, 8'h00);
        push_op(tts_pkg::OP_DISPATCH, 16'h0000, 32'h0, 32'h0, 8'h00);
        push_op(tts_pkg::OP_DISPATCH, 16'h0000, 32'h0, 32'h0, 8'h00);
        push_op(tts_pkg::OP_DELETE,   16'h0000, 32'h0, 32'h0, 8'h01);
        push_op(tts_pkg::OP_DELETE,   16'h0000, 32'h0, 32'h0, 8'h02);
        push_op(tts_pkg::OP_ADD,      16'h00FF, 32'h2, 32'h0, 8'h00);
        repeat (3) push_op(tts_pkg::OP_TICK, 16'h0000, 32'h0, 32'h0, 8'h00);
        push_op(tts_pkg::OP_DISPATCH, 16'h0000, 32'h0, 32'h0, 8'h00);
        push_op(tts_pkg::OP_DELETE,   16'h0000, 32'h0, 32'h0, 8'h00);
        push_op(tts_pkg::OP_DISPATCH, 16'h0000, 32'h0, 32'h0, 8'h00);

        while (made < RANDOM_ITEMS) begin
            if (!long_done && made >= long_at) begin
                push_op(tts_pkg::OP_DELETE, 16'($urandom()), $urandom(), $urandom(), 8'h00);
                push_op(tts_pkg::OP_ADD, 16'($urandom()), 32'h0, 32'h0, 8'($urandom()));
                repeat (SATURATE_TICKS) push_random(tts_pkg::OP_TICK);
                push_random(tts_pkg::OP_DISPATCH);
                made += SATURATE_TICKS + 3;
                long_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                n = $urandom_range(2, 10);
                repeat (n) push_random(tts_pkg::OP_TICK);
                made += n;
            end else if (r < 12) begin
                repeat (TASKS + 1) push_random(tts_pkg::OP_ADD);
                made += TASKS + 1;
            end else if (r < 15) begin
                for (int s = 0; s <= TASKS; s++) begin
                    push_op(tts_pkg::OP_DELETE, 16'($urandom()), $urandom(), $urandom(), 8'(s));
                end
                made += TASKS + 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35) push_random(tts_pkg::OP_TICK);
                else if (r < 55) push_random(tts_pkg::OP_ADD);
                else if (r < 75) push_random(tts_pkg::OP_DELETE);
                else push_random(tts_pkg::OP_DISPATCH);
                made++;
            end
        end

        wait (rst_n);
        while (ops_to_send.size() != 0 || in_valid) @(posedge clk);
        while (reports_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0) begin
            $display("time_triggered_task_scheduler_tb OK");
        end else begin
            $display("time_triggered_task_scheduler_tb NOT OK");
        end
        $finish;
    end

endmodule
